@@ rtl/lrs_pkg.sv @@
// Package for the link reconnect supervisor: item, result, state and config types,
// event kinds, status codes, register indexes and fixed timing constants.
// No dependencies.
`default_nettype none

package lrs_pkg;

    // Event kinds carried by an input beat.
    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_PROBE    = 2'd1;
    localparam logic [1:0] KIND_RECONFIG = 2'd2;

    // Status codes reported with every result beat.
    localparam logic [3:0] ST_IDLE        = 4'd0;
    localparam logic [3:0] ST_OK          = 4'd1;
    localparam logic [3:0] ST_UNREACHABLE = 4'd2;
    localparam logic [3:0] ST_CONNECT_ERR = 4'd3;
    localparam logic [3:0] ST_PROBE_LOST  = 4'd4;
    localparam logic [3:0] ST_DROPPED     = 4'd5;
    localparam logic [3:0] ST_PING_FAIL   = 4'd6;
    localparam logic [3:0] ST_WIFI_OFF    = 4'd7;
    localparam logic [3:0] ST_RECONFIG    = 4'd8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTITY_PERIOD = 3'd5;

    // Register reset values.
    localparam logic [31:0] BACKOFF_BASE_RST  = 32'd5000;
    localparam logic [31:0] BACKOFF_MAX_RST   = 32'd60000;
    localparam logic [31:0] PING_INTERVAL_RST = 32'd30000;
    localparam logic [31:0] STATE_PERIOD_RST  = 32'd60000;
    localparam logic [31:0] ENTITY_PERIOD_RST = 32'd60000;

    // Fixed timeouts in milliseconds.
    localparam logic [31:0] LOST_MS  = 32'd30000;
    localparam logic [31:0] DEFER_MS = 32'd60000;
    localparam logic [31:0] QFULL_MS = 32'd5000;

    // Link mode, one-hot.
    typedef enum logic [2:0] {
        MODE_OFF   = 3'b001,
        MODE_PROBE = 3'b010,
        MODE_UP    = 3'b100
    } t_mode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic        wifi_up;
        logic        sock_connected;
        logic        write_ok;
        logic        queue_accepts;
        logic        probe_ok;
        logic        probe_deferred;
        logic        connect_ok;
    } t_in_item;

    typedef struct packed {
        logic       start_probe;
        logic       send_ping;
        logic       announce_online;
        logic       send_state;
        logic       send_entities;
        logic       close_link;
        logic       connected;
        logic [3:0] status_code;
    } t_out_item;

    typedef struct packed {
        logic        link_enable;
        logic [31:0] backoff_base_ms;
        logic [31:0] backoff_max_ms;
        logic [31:0] ping_interval_ms;
        logic [31:0] state_period_ms;
        logic [31:0] entity_period_ms;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic        probe_pending;
        logic [31:0] probe_start;
        logic [31:0] retry_at;
        logic [31:0] backoff_now;
        logic [31:0] last_ping_at;
        logic [31:0] last_state_at;
        logic [31:0] last_entity_at;
        logic [3:0]  status_reg;
    } t_state;

endpackage

`default_nettype wire

@@ rtl/lrs_step.sv @@
// Next-state and result logic for one event of the link reconnect supervisor.
// Purely combinational; depends on lrs_pkg.
`default_nettype none

module lrs_step (
    input  lrs_pkg::t_state    i_state,
    input  lrs_pkg::t_cfg      i_cfg,
    input  lrs_pkg::t_in_item  i_item,
    output lrs_pkg::t_state    o_state,
    output lrs_pkg::t_out_item o_result
);
    import lrs_pkg::*;

    logic [31:0] w_now;
    logic [32:0] w_dbl;
    logic [31:0] w_grown;
    logic [31:0] w_retry_backoff;
    logic [31:0] w_neg_backoff;
    logic [31:0] w_retry_diff;
    logic [31:0] w_probe_age;
    logic        w_ping_due;
    logic        w_state_due;
    logic        w_entity_due;
    logic        w_lost;
    logic        w_retry_due;
    t_state      n_state;
    t_out_item   n_result;

    assign w_now = i_item.now_ms;

    // Doubled backoff, saturating at the configured ceiling.
    assign w_dbl   = {i_state.backoff_now, 1'b0};
    assign w_grown = (w_dbl > {1'b0, i_cfg.backoff_max_ms}) ? i_cfg.backoff_max_ms
                                                             : w_dbl[31:0];

    // Time arithmetic, all modulo 2^32 and evaluated side by side.
    assign w_retry_backoff = w_now + i_state.backoff_now;
    assign w_neg_backoff   = 32'd0 - i_state.backoff_now;
    assign w_retry_diff    = w_now - i_state.retry_at;
    assign w_probe_age     = w_now - i_state.probe_start;
    assign w_ping_due   = (w_now - i_state.last_ping_at)   >= i_cfg.ping_interval_ms;
    assign w_state_due  = (w_now - i_state.last_state_at)  >= i_cfg.state_period_ms;
    assign w_entity_due = (w_now - i_state.last_entity_at) >= i_cfg.entity_period_ms;

    // A probe in flight too long is abandoned; the retry may then fire on this tick.
    assign w_lost = (i_state.mode == MODE_PROBE) && (w_probe_age > LOST_MS);
    always_comb begin
        if (w_lost) begin
            // After a lost probe the retry time is now + backoff.
            w_retry_due = !w_neg_backoff[31];
        end else begin
            w_retry_due = (i_state.mode != MODE_PROBE) && (i_state.mode != MODE_UP) &&
                          !i_state.probe_pending && !w_retry_diff[31];
        end
    end

    // Event handling.
    always_comb begin
        n_state  = i_state;
        n_result = '0;
        case (i_item.kind)
            KIND_RECONFIG: begin
                n_result.close_link = (i_state.mode == MODE_UP);
                n_state.mode        = MODE_OFF;
                n_state.status_reg  = ST_RECONFIG;
                n_state.retry_at    = '0;
                n_state.backoff_now = i_cfg.backoff_base_ms;
            end
            KIND_PROBE: begin
                n_state.probe_pending = 1'b0;
                if (i_cfg.link_enable && (i_state.mode == MODE_PROBE)) begin
                    if (i_item.probe_deferred) begin
                        n_state.retry_at = w_now + DEFER_MS;
                        n_state.mode     = MODE_OFF;
                    end else if (!i_item.probe_ok) begin
                        n_state.status_reg  = ST_UNREACHABLE;
                        n_state.mode        = MODE_OFF;
                        n_state.retry_at    = w_retry_backoff;
                        n_state.backoff_now = w_grown;
                    end else if (i_item.connect_ok) begin
                        n_state.mode             = MODE_UP;
                        n_state.backoff_now      = i_cfg.backoff_base_ms;
                        n_state.status_reg       = ST_OK;
                        n_result.announce_online = 1'b1;
                        n_state.last_state_at    = w_now;
                        n_state.last_entity_at   = w_now;
                        n_state.last_ping_at     = w_now;
                    end else begin
                        n_state.status_reg  = ST_CONNECT_ERR;
                        n_state.mode        = MODE_OFF;
                        n_state.retry_at    = w_retry_backoff;
                        n_state.backoff_now = w_grown;
                    end
                end
            end
            KIND_TICK: begin
                if (!i_cfg.link_enable || !i_item.wifi_up) begin
                    // Link disabled or no network: drop to off.
                    if ((i_state.mode == MODE_PROBE) || (i_state.mode == MODE_UP)) begin
                        n_result.close_link = (i_state.mode == MODE_UP);
                        n_state.mode        = MODE_OFF;
                        n_state.status_reg  = ST_WIFI_OFF;
                    end
                end else if (i_state.mode == MODE_UP) begin
                    if (!i_item.sock_connected) begin
                        n_result.close_link = 1'b1;
                        n_state.mode        = MODE_OFF;
                        n_state.status_reg  = ST_DROPPED;
                        n_state.retry_at    = w_retry_backoff;
                    end else if (w_ping_due && !i_item.write_ok) begin
                        n_result.close_link = 1'b1;
                        n_state.mode        = MODE_OFF;
                        n_state.status_reg  = ST_PING_FAIL;
                        n_state.retry_at    = w_retry_backoff;
                    end else begin
                        if (w_ping_due) begin
                            n_result.send_ping   = 1'b1;
                            n_state.last_ping_at = w_now;
                        end
                        if (w_state_due) begin
                            n_result.send_state   = 1'b1;
                            n_state.last_state_at = w_now;
                        end
                        if (w_entity_due) begin
                            n_result.send_entities = 1'b1;
                            n_state.last_entity_at = w_now;
                        end
                    end
                end else begin
                    // Off or probing: watch for a lost probe, then for the retry time.
                    if (w_lost) begin
                        n_state.probe_pending = 1'b0;
                        n_state.mode          = MODE_OFF;
                        n_state.retry_at      = w_retry_backoff;
                        n_state.status_reg    = ST_PROBE_LOST;
                    end
                    if (w_retry_due) begin
                        if (i_item.queue_accepts) begin
                            n_result.start_probe  = 1'b1;
                            n_state.probe_pending = 1'b1;
                            n_state.mode          = MODE_PROBE;
                            n_state.probe_start   = w_now;
                        end else begin
                            n_state.retry_at = w_now + QFULL_MS;
                        end
                    end
                end
            end
            default: begin
                n_state = i_state;
            end
        endcase
        n_result.connected   = (n_state.mode == MODE_UP);
        n_result.status_code = n_state.status_reg;
    end

    assign o_state  = n_state;
    assign o_result = n_result;

endmodule

`default_nettype wire

@@ rtl/link_reconnect_supervisor.sv @@
// Link reconnect supervisor: input register, combinational event logic, result register.
// Depends on lrs_pkg and lrs_step.
// A result beat is registered when its event leaves the input register, which waits on a full
// result register. Throughput: one event per cycle while results are taken; the next event sees
// the state left by the previous one because the state registers load with the result register.
// Reset (synchronous, active low) empties both registers and returns the mode to off,
// the backoff to its base value and all configuration registers to their defaults.
`default_nettype none

module link_reconnect_supervisor (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  lrs_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output lrs_pkg::t_out_item             o_out,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [lrs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [31:0]                     i_cfg_data
);
    import lrs_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_state    r_state;
    t_cfg      r_cfg;
    t_state    n_state;
    t_out_item n_out;
    logic      w_out_load;
    logic      w_step_fire;

    // Handshake: the result register frees up when empty or when its beat is taken.
    assign w_out_load  = !r_out_valid || i_out_ready;
    assign w_step_fire = r_in_valid && w_out_load;
    assign o_in_ready  = !r_in_valid || w_step_fire;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    lrs_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Input beat payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // Result beat payload.
    always_ff @(posedge i_clk) begin
        if (w_step_fire) begin
            r_out <= n_out;
        end
    end

    // Valid flags and supervisor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid             <= 1'b0;
            r_out_valid            <= 1'b0;
            r_state.mode           <= MODE_OFF;
            r_state.probe_pending  <= 1'b0;
            r_state.probe_start    <= '0;
            r_state.retry_at       <= '0;
            r_state.backoff_now    <= BACKOFF_BASE_RST;
            r_state.last_ping_at   <= '0;
            r_state.last_state_at  <= '0;
            r_state.last_entity_at <= '0;
            r_state.status_reg     <= ST_IDLE;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step_fire) begin
                r_state <= n_state;
            end
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_enable      <= 1'b0;
            r_cfg.backoff_base_ms  <= BACKOFF_BASE_RST;
            r_cfg.backoff_max_ms   <= BACKOFF_MAX_RST;
            r_cfg.ping_interval_ms <= PING_INTERVAL_RST;
            r_cfg.state_period_ms  <= STATE_PERIOD_RST;
            r_cfg.entity_period_ms <= ENTITY_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LINK_ENABLE:   r_cfg.link_enable      <= i_cfg_data[0];
                CFG_BACKOFF_BASE:  r_cfg.backoff_base_ms  <= i_cfg_data;
                CFG_BACKOFF_MAX:   r_cfg.backoff_max_ms   <= i_cfg_data;
                CFG_PING_INTERVAL: r_cfg.ping_interval_ms <= i_cfg_data;
                CFG_STATE_PERIOD:  r_cfg.state_period_ms  <= i_cfg_data;
                CFG_ENTITY_PERIOD: r_cfg.entity_period_ms <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // A processed event always leaves a result beat behind it.
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_fire |=> r_out_valid)
        else $error("result register empty after an event was processed");

    // The link can only be closed from the up mode.
    a_close_from_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step_fire && n_out.close_link) |-> (r_state.mode == MODE_UP))
        else $error("close_link raised while the link was not up");

    // The connected flag of a result matches the mode it leaves behind.
    a_connected_tracks_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_fire |=> (r_out.connected == (r_state.mode == MODE_UP)))
        else $error("connected flag disagrees with the stored mode");

    // Launching a probe marks it pending and enters probing.
    a_probe_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step_fire && n_out.start_probe) |=>
            (r_state.probe_pending && (r_state.mode == MODE_PROBE)))
        else $error("probe launched without the pending flag and probing mode");

    // Coming online is only ever reported with the link up.
    a_announce_connected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step_fire && n_out.announce_online) |-> n_out.connected)
        else $error("announce_online without the link up");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench for link_reconnect_supervisor: directed and random event beats checked against
// an in-bench model of the link modes, backoff and periodic actions.
// Depends on lrs_pkg and the RTL of the supervisor.

module tb;
    import lrs_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    // Model copy of the registers and the link state.
    t_cfg       regs;
    t_state     lk;
    logic [31:0] sim_ms;
    t_out_item  pending_actions[$];
    int         failures = 0;
    bit         quiet = 1'b0;
    bit         sink_hold_req = 1'b0;
    int         src_idle_pct = 10;
    int         sink_idle_pct = 10;

    link_reconnect_supervisor dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in, .o_out_valid, .i_out_ready,
        .o_out, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // True once at least one period has passed since the given stamp, modulo 2^32.
    function automatic logic aged(input logic [31:0] at, input logic [31:0] since,
                                  input logic [31:0] period);
        logic [31:0] d;
        d = at - since;
        return d >= period;
    endfunction

    // Advances the model by one event and returns the actions it produces.
    function automatic t_out_item next_actions(input t_in_item ev);
        t_out_item   r;
        logic [31:0] t;
        logic [31:0] d;
        logic [32:0] dbl;
        r = '0;
        t = ev.now_ms;
        case (ev.kind)
            KIND_RECONFIG: begin
                r.close_link = (lk.mode == MODE_UP);
                lk.mode = MODE_OFF;
                lk.status_reg = ST_RECONFIG;
                lk.retry_at = '0;
                lk.backoff_now = regs.backoff_base_ms;
            end
            KIND_PROBE: begin
                // A result always frees the probe slot, but only counts while probing.
                lk.probe_pending = 1'b0;
                if (regs.link_enable && lk.mode == MODE_PROBE) begin
                    if (ev.probe_deferred) begin
                        lk.retry_at = t + DEFER_MS;
                        lk.mode = MODE_OFF;
                    end else if (!ev.probe_ok || !ev.connect_ok) begin
                        lk.status_reg = ev.probe_ok ? ST_CONNECT_ERR : ST_UNREACHABLE;
                        lk.mode = MODE_OFF;
                        lk.retry_at = t + lk.backoff_now;
                        dbl = {lk.backoff_now, 1'b0};
                        if (dbl > {1'b0, regs.backoff_max_ms}) begin
                            dbl = {1'b0, regs.backoff_max_ms};
                        end
                        lk.backoff_now = dbl[31:0];
                    end else begin
                        lk.mode = MODE_UP;
                        lk.backoff_now = regs.backoff_base_ms;
                        lk.status_reg = ST_OK;
                        r.announce_online = 1'b1;
                        lk.last_state_at = t;
                        lk.last_entity_at = t;
                        lk.last_ping_at = t;
                    end
                end
            end
            KIND_TICK: begin
                if (!regs.link_enable || !ev.wifi_up) begin
                    if (lk.mode != MODE_OFF) begin
                        r.close_link = (lk.mode == MODE_UP);
                        lk.mode = MODE_OFF;
                        lk.status_reg = ST_WIFI_OFF;
                    end
                end else if (lk.mode == MODE_UP) begin
                    if (!ev.sock_connected) begin
                        r.close_link = 1'b1;
                        lk.mode = MODE_OFF;
                        lk.status_reg = ST_DROPPED;
                        lk.retry_at = t + lk.backoff_now;
                    end else if (aged(t, lk.last_ping_at, regs.ping_interval_ms) &&
                                 !ev.write_ok) begin
                        r.close_link = 1'b1;
                        lk.mode = MODE_OFF;
                        lk.status_reg = ST_PING_FAIL;
                        lk.retry_at = t + lk.backoff_now;
                    end else begin
                        if (aged(t, lk.last_ping_at, regs.ping_interval_ms)) begin
                            r.send_ping = 1'b1;
                            lk.last_ping_at = t;
                        end
                        if (aged(t, lk.last_state_at, regs.state_period_ms)) begin
                            r.send_state = 1'b1;
                            lk.last_state_at = t;
                        end
                        if (aged(t, lk.last_entity_at, regs.entity_period_ms)) begin
                            r.send_entities = 1'b1;
                            lk.last_entity_at = t;
                        end
                    end
                end else begin
                    // A probe out for too long is dropped; the retry check may restart it.
                    d = t - lk.probe_start;
                    if (lk.mode == MODE_PROBE && d > LOST_MS) begin
                        lk.probe_pending = 1'b0;
                        lk.mode = MODE_OFF;
                        lk.retry_at = t + lk.backoff_now;
                        lk.status_reg = ST_PROBE_LOST;
                    end
                    d = t - lk.retry_at;
                    if (lk.mode == MODE_OFF && !lk.probe_pending && !d[31]) begin
                        if (ev.queue_accepts) begin
                            r.start_probe = 1'b1;
                            lk.probe_pending = 1'b1;
                            lk.mode = MODE_PROBE;
                            lk.probe_start = t;
                        end else begin
                            lk.retry_at = t + QFULL_MS;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.connected = (lk.mode == MODE_UP);
        r.status_code = lk.status_reg;
        return r;
    endfunction

    // Offers one event beat, books its expected actions on acceptance, then maybe idles.
    task automatic send_event(input t_in_item ev);
        int gap;
        i_in <= ev;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_actions.push_back(next_actions(ev));
        if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic tick_at(input logic [31:0] at, input logic wifi, input logic sock,
                           input logic wok, input logic qok);
        t_in_item ev;
        ev = '0;
        ev.kind = KIND_TICK;
        ev.now_ms = at;
        ev.wifi_up = wifi;
        ev.sock_connected = sock;
        ev.write_ok = wok;
        ev.queue_accepts = qok;
        send_event(ev);
    endtask

    task automatic probe_at(input logic [31:0] at, input logic ok, input logic deferred,
                            input logic conn);
        t_in_item ev;
        ev = '0;
        ev.kind = KIND_PROBE;
        ev.now_ms = at;
        ev.probe_ok = ok;
        ev.probe_deferred = deferred;
        ev.connect_ok = conn;
        send_event(ev);
    endtask

    task automatic plain_event(input logic [1:0] kind, input logic [31:0] at);
        t_in_item ev;
        ev = '0;
        ev.kind = kind;
        ev.now_ms = at;
        send_event(ev);
    endtask

    // Drops the input valid and waits until every expected beat has been checked.
    task automatic settle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_actions.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_actions.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_actions.size());
            failures++;
            pending_actions.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes all six registers back to back while the block is idle.
    task automatic configure(input t_cfg c);
        settle();
        write_reg(CFG_LINK_ENABLE, {31'd0, c.link_enable});
        write_reg(CFG_BACKOFF_BASE, c.backoff_base_ms);
        write_reg(CFG_BACKOFF_MAX, c.backoff_max_ms);
        write_reg(CFG_PING_INTERVAL, c.ping_interval_ms);
        write_reg(CFG_STATE_PERIOD, c.state_period_ms);
        write_reg(CFG_ENTITY_PERIOD, c.entity_period_ms);
        i_cfg_valid <= 1'b0;
        regs = c;
    endtask

    function automatic logic [31:0] pick_ms();
        int          sel;
        logic [31:0] v;
        sel = $urandom_range(0, 4);
        if (sel == 0) return 32'd1;
        if (sel == 1) return 32'hFFFF_FFFF;
        if (sel == 2) return $urandom_range(1, 200);
        if (sel == 3) return $urandom_range(1000, 90000);
        v = $urandom;
        return (v == 0) ? 32'd1 : v;
    endfunction

    function automatic int pick_idle_pct();
        int sel;
        sel = $urandom_range(0, 2);
        return (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
    endfunction

    // Mostly well-formed traffic: results follow probes, time jumps to due retries.
    function automatic t_in_item random_event();
        t_in_item ev;
        int       sel;
        ev.wifi_up = ($urandom_range(0, 99) < 94);
        ev.sock_connected = ($urandom_range(0, 99) < 95);
        ev.write_ok = ($urandom_range(0, 99) < 85);
        ev.queue_accepts = ($urandom_range(0, 99) < 80);
        ev.probe_ok = ($urandom_range(0, 99) < 70);
        ev.probe_deferred = ($urandom_range(0, 99) < 12);
        ev.connect_ok = ($urandom_range(0, 99) < 75);
        sel = $urandom_range(0, 99);
        if (lk.mode == MODE_OFF && sel < 12) sim_ms = lk.retry_at + $urandom_range(0, 3);
        else if (sel < 50) sim_ms = sim_ms + $urandom_range(0, 2000);
        else if (sel < 90) sim_ms = sim_ms + $urandom_range(0, 70000);
        else if (sel < 97) sim_ms = sim_ms + $urandom_range(25000, 35000);
        else sim_ms = $urandom;
        ev.now_ms = sim_ms;
        sel = $urandom_range(0, 99);
        if (lk.mode == MODE_PROBE) begin
            ev.kind = (sel < 55) ? KIND_PROBE : (sel < 96) ? KIND_TICK :
                      (sel < 98) ? KIND_RECONFIG : KIND_UNUSED;
        end else begin
            ev.kind = (sel < 88) ? KIND_TICK : (sel < 94) ? KIND_PROBE :
                      (sel < 98) ? KIND_RECONFIG : KIND_UNUSED;
        end
        return ev;
    endfunction

    // Result side: ready with random stall bursts and, on request, one long hold-off.
    initial begin : sink_side
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < sink_idle_pct) begin
                    stall_left = $urandom_range(1, 18);
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Each accepted result beat is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_actions.size() == 0) begin
                $error("result beat arrived with nothing expected");
                failures++;
            end else begin
                want = pending_actions.pop_front();
                check_field("start_probe", want.start_probe, o_out.start_probe);
                check_field("send_ping", want.send_ping, o_out.send_ping);
                check_field("announce_online", want.announce_online, o_out.announce_online);
                check_field("send_state", want.send_state, o_out.send_state);
                check_field("send_entities", want.send_entities, o_out.send_entities);
                check_field("close_link", want.close_link, o_out.close_link);
                check_field("connected", want.connected, o_out.connected);
                check_field("status_code", want.status_code, o_out.status_code);
            end
        end
    end

    // Disabled link straight out of reset: nothing starts, stray beats are harmless.
    task automatic test_idle_after_reset();
        tick_at(32'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        probe_at(32'd10, 1'b1, 1'b0, 1'b1);
        plain_event(KIND_UNUSED, 32'hFFFF_FFFF);
        plain_event(KIND_RECONFIG, 32'd20);
    endtask

    // One walk through the probe, connect and drop transitions with the default timing.
    task automatic test_connect_cycle();
        t_cfg c;
        c = regs;
        c.link_enable = 1'b1;
        configure(c);
        tick_at(32'd0, 1'b1, 1'b1, 1'b1, 1'b0);         // queue full pushes the retry out
        tick_at(32'd4999, 1'b1, 1'b1, 1'b1, 1'b1);      // one millisecond early
        tick_at(32'd5000, 1'b1, 1'b1, 1'b1, 1'b1);
        probe_at(32'd6000, 1'b0, 1'b1, 1'b0);           // deferred
        tick_at(32'd66000, 1'b1, 1'b1, 1'b1, 1'b1);
        probe_at(32'd67000, 1'b0, 1'b0, 1'b0);          // unreachable
        tick_at(32'd72000, 1'b1, 1'b1, 1'b1, 1'b1);
        probe_at(32'd72500, 1'b1, 1'b0, 1'b0);          // handshake fails
        tick_at(32'd82500, 1'b1, 1'b1, 1'b1, 1'b1);
        tick_at(32'd112501, 1'b1, 1'b1, 1'b1, 1'b1);    // probe lost
        probe_at(32'd112600, 1'b1, 1'b0, 1'b1);         // late result of the lost probe
        tick_at(32'd132501, 1'b1, 1'b1, 1'b1, 1'b1);
        probe_at(32'd133000, 1'b1, 1'b0, 1'b1);         // link up
        tick_at(32'd163000, 1'b1, 1'b1, 1'b1, 1'b1);
        tick_at(32'd193000, 1'b1, 1'b1, 1'b1, 1'b1);
        tick_at(32'd223000, 1'b1, 1'b1, 1'b0, 1'b1);    // ping write refused
        tick_at(32'd228000, 1'b1, 1'b1, 1'b1, 1'b1);
        probe_at(32'd228100, 1'b1, 1'b0, 1'b1);
        tick_at(32'd228200, 1'b1, 1'b0, 1'b1, 1'b1);    // socket dropped
        tick_at(32'd233200, 1'b1, 1'b1, 1'b1, 1'b1);
        probe_at(32'd233300, 1'b1, 1'b0, 1'b1);
        tick_at(32'd233400, 1'b0, 1'b1, 1'b1, 1'b1);    // wifi lost while up
        tick_at(32'd240000, 1'b1, 1'b1, 1'b1, 1'b1);
        tick_at(32'd240100, 1'b0, 1'b1, 1'b1, 1'b1);    // wifi lost with a probe out
        tick_at(32'd250000, 1'b1, 1'b1, 1'b1, 1'b1);    // probe still pending, no restart
        sim_ms = 32'd250000;
    endtask

    // Backoff saturation at the register extremes, and a lost probe restarting at once.
    task automatic test_backoff_limits();
        t_cfg        c;
        logic [31:0] bases[3] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'd1};
        logic [31:0] maxes[3] = '{32'd1, 32'hFFFF_FFFF, 32'd3};
        int          s;
        int          k;
        c = regs;
        c.link_enable = 1'b1;
        c.ping_interval_ms = 32'd1;
        c.state_period_ms = 32'd1;
        c.entity_period_ms = 32'd1;
        for (s = 0; s < 3; s++) begin
            c.backoff_base_ms = bases[s];
            c.backoff_max_ms = maxes[s];
            configure(c);
            plain_event(KIND_RECONFIG, 32'd100);
            for (k = 0; k < 3; k++) begin
                tick_at(lk.retry_at, 1'b1, 1'b1, 1'b1, 1'b1);
                probe_at(lk.probe_start + 7, k[0], 1'b0, 1'b0);
            end
            tick_at(lk.retry_at, 1'b1, 1'b1, 1'b1, 1'b1);
            probe_at(lk.probe_start + 9, 1'b1, 1'b0, 1'b1);
            tick_at(lk.probe_start + 20, 1'b1, 1'b1, 1'b1, 1'b1);
        end
        c.backoff_base_ms = 32'hFFFF_FFFF;
        c.backoff_max_ms = 32'hFFFF_FFFF;
        c.ping_interval_ms = 32'hFFFF_FFFF;
        c.state_period_ms = 32'hFFFF_FFFF;
        c.entity_period_ms = 32'hFFFF_FFFF;
        configure(c);
        plain_event(KIND_RECONFIG, 32'd0);
        tick_at(32'd1000, 1'b1, 1'b1, 1'b1, 1'b1);
        tick_at(32'd31001, 1'b1, 1'b1, 1'b1, 1'b1);
        tick_at(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        probe_at(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
        tick_at(32'hFFFF_FFFE, 1'b1, 1'b1, 1'b1, 1'b1);  // a full period later, modulo 2^32
        plain_event(KIND_RECONFIG, 32'hFFFF_FFFE);        // reconfigured while up
        plain_event(KIND_UNUSED, 32'd0);
        sim_ms = 32'd0;
    endtask

    // Random traffic over several register settings, the extremes first.
    task automatic test_random_phases();
        t_cfg c;
        int   p;
        int   count;
        for (p = 0; p < 8; p++) begin
            if (p == 0) begin
                c = '{1'b1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1};
            end else if (p == 1) begin
                c = '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF};
            end else begin
                c.link_enable = (p != 4);
                c.backoff_base_ms = pick_ms();
                c.backoff_max_ms = pick_ms();
                c.ping_interval_ms = pick_ms();
                c.state_period_ms = pick_ms();
                c.entity_period_ms = pick_ms();
            end
            configure(c);
            src_idle_pct = pick_idle_pct();
            sink_idle_pct = pick_idle_pct();
            count = (p == 4) ? 60 : 190;
            repeat (count) send_event(random_event());
        end
    endtask

    // The receiver holds off for a long stretch while events keep coming.
    task automatic test_backpressure();
        t_cfg c;
        c = '{1'b1, 32'd500, 32'd8000, 32'd2000, 32'd5000, 32'd7000};
        configure(c);
        src_idle_pct = 0;
        sink_hold_req = 1'b1;
        repeat (40) send_event(random_event());
    endtask

    // Closing stretch with both sides running flat out.
    task automatic test_quiet_tail();
        quiet = 1'b1;
        repeat (150) send_event(random_event());
    endtask

    initial begin
        regs = '{1'b0, BACKOFF_BASE_RST, BACKOFF_MAX_RST, PING_INTERVAL_RST,
                 STATE_PERIOD_RST, ENTITY_PERIOD_RST};
        lk = '0;
        lk.mode = MODE_OFF;
        lk.backoff_now = BACKOFF_BASE_RST;
        lk.status_reg = ST_IDLE;
        sim_ms = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_after_reset();
        test_connect_cycle();
        test_backoff_limits();
        test_random_phases();
        test_backpressure();
        test_quiet_tail();
        settle();

        if (failures == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lrs_pkg.sv
rtl/lrs_step.sv
rtl/link_reconnect_supervisor.sv
sim/tb.sv
